FILE: sv/rdz_pkg.sv
// rdz_pkg: shared widths and payload types for the radial dead-zone scaler.
// No dependencies.
package rdz_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int RADIUS_WIDTH = 16;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] in_x;
    logic signed [SAMPLE_WIDTH-1:0] in_y;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_x;
    logic signed [SAMPLE_WIDTH-1:0] out_y;
  } out_item_t;

endpackage

FILE: sv/radial_dead_zone_scaler.sv
// radial_dead_zone_scaler: pipelined radial dead zone on a signed 2-D vector.
// Depends on rdz_pkg (widths, in_item_t, out_item_t).
// Stages in order: A, B, C, the isqrt steps, D, E, the divide steps, output.
// Throughput: one item per cycle; busy is always low, since the isqrt and the
// divider are unrolled into one stage per result bit.
// Reset (rst_n low, synchronous): clears all stage valid bits and the radius.
module radial_dead_zone_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rdz_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  output rdz_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [rdz_pkg::RADIUS_WIDTH-1:0]   cfg_wdata
);

  localparam int W  = rdz_pkg::SAMPLE_WIDTH;
  localparam int RW = rdz_pkg::RADIUS_WIDTH;
  localparam int CW = (W > RW) ? W : RW;   // compare width for m vs radius

  // no backpressure anywhere: the pipeline takes an item every cycle
  assign busy = 1'b0;

  logic [RW-1:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // ---------------- stage A: magnitudes and signs ----------------
  logic         a_vld_r;
  logic [W-1:0] a_ax_r, a_ay_r;
  logic         a_nx_r, a_ny_r;
  logic [W-1:0] a_ax_nxt, a_ay_nxt;

  always_comb begin
    // two's complement negate; the most negative code maps onto itself,
    // which read unsigned is the right magnitude
    a_ax_nxt = in_data.in_x[W-1] ? (~in_data.in_x + 1'b1) : in_data.in_x;
    a_ay_nxt = in_data.in_y[W-1] ? (~in_data.in_y + 1'b1) : in_data.in_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
    end
    a_ax_r <= a_ax_nxt;
    a_ay_r <= a_ay_nxt;
    a_nx_r <= in_data.in_x[W-1];
    a_ny_r <= in_data.in_y[W-1];
  end

  // ---------------- stage B: squares ----------------
  logic           b_vld_r;
  logic [W-1:0]   b_ax_r, b_ay_r;
  logic           b_nx_r, b_ny_r;
  logic [2*W-1:0] b_sx_r, b_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_ax_r <= a_ax_r;
    b_ay_r <= a_ay_r;
    b_nx_r <= a_nx_r;
    b_ny_r <= a_ny_r;
    b_sx_r <= a_ax_r * a_ax_r;
    b_sy_r <= a_ay_r * a_ay_r;
  end

  // ---------------- stage C: sum of squares ----------------
  // each square is at most 2^(2W-2), so the sum fits 2W bits
  // sqrt pipeline arrays: index k holds the input of isqrt step k
  logic           q_vld_r  [0:W];
  logic [W-1:0]   q_ax_r   [0:W];
  logic [W-1:0]   q_ay_r   [0:W];
  logic           q_nx_r   [0:W];
  logic           q_ny_r   [0:W];
  logic [2*W-1:0] q_v_r    [0:W];   // radicand, consumed two bits per step
  logic [W:0]     q_rem_r  [0:W];
  logic [W-1:0]   q_root_r [0:W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r[0] <= 1'b0;
    end else begin
      q_vld_r[0] <= b_vld_r;
    end
    q_ax_r[0]   <= b_ax_r;
    q_ay_r[0]   <= b_ay_r;
    q_nx_r[0]   <= b_nx_r;
    q_ny_r[0]   <= b_ny_r;
    q_v_r[0]    <= b_sx_r + b_sy_r;
    q_rem_r[0]  <= '0;
    q_root_r[0] <= '0;
  end

  // ---------------- isqrt: one root bit per stage ----------------
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [W+2:0] remsh_nxt, trial_nxt, diff_nxt;
    logic         take_nxt;

    always_comb begin
      remsh_nxt = {q_rem_r[k], q_v_r[k][2*W-1:2*W-2]};
      trial_nxt = {1'b0, q_root_r[k], 2'b01};
      diff_nxt  = remsh_nxt - trial_nxt;
      take_nxt  = (remsh_nxt >= trial_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_vld_r[k+1] <= 1'b0;
      end else begin
        q_vld_r[k+1] <= q_vld_r[k];
      end
      q_ax_r[k+1]   <= q_ax_r[k];
      q_ay_r[k+1]   <= q_ay_r[k];
      q_nx_r[k+1]   <= q_nx_r[k];
      q_ny_r[k+1]   <= q_ny_r[k];
      q_v_r[k+1]    <= {q_v_r[k][2*W-3:0], 2'b00};
      // remainder stays below 2*root+1 < 2^(W+1)
      q_rem_r[k+1]  <= take_nxt ? diff_nxt[W:0] : remsh_nxt[W:0];
      q_root_r[k+1] <= {q_root_r[k][W-2:0], take_nxt};
    end
  end

  // ---------------- stage D: dead-zone test and d = m - r ----------------
  logic         d_vld_r, d_zero_r;
  logic [W-1:0] d_ax_r, d_ay_r, d_m_r, d_d_r;
  logic         d_nx_r, d_ny_r;
  logic [CW-1:0] d_mext_nxt, d_rext_nxt, d_diff_nxt;

  always_comb begin
    d_mext_nxt = CW'(q_root_r[W]);
    d_rext_nxt = CW'(radius_r);
    d_diff_nxt = d_mext_nxt - d_rext_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= q_vld_r[W];
    end
    d_zero_r <= (d_mext_nxt <= d_rext_nxt);
    d_ax_r   <= q_ax_r[W];
    d_ay_r   <= q_ay_r[W];
    d_nx_r   <= q_nx_r[W];
    d_ny_r   <= q_ny_r[W];
    d_m_r    <= q_root_r[W];
    d_d_r    <= d_diff_nxt[W-1:0];   // only used when m > r, so d < 2^W
  end

  // ---------------- stage E: products |c| * d ----------------
  // divider arrays: index k holds the input of quotient step k
  logic           v_vld_r  [0:W];
  logic           v_zero_r [0:W];
  logic           v_nx_r   [0:W];
  logic           v_ny_r   [0:W];
  logic [W-1:0]   v_m_r    [0:W];
  logic [2*W-1:0] v_px_r   [0:W];   // dividend, low half shifted in per step
  logic [2*W-1:0] v_py_r   [0:W];
  logic [W:0]     v_rx_r   [0:W];   // partial remainders
  logic [W:0]     v_ry_r   [0:W];
  logic [W-1:0]   v_qx_r   [0:W];
  logic [W-1:0]   v_qy_r   [0:W];
  logic [2*W-1:0] e_px_nxt, e_py_nxt;

  always_comb begin
    e_px_nxt = d_ax_r * d_d_r;
    e_py_nxt = d_ay_r * d_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r[0] <= 1'b0;
    end else begin
      v_vld_r[0] <= d_vld_r;
    end
    v_zero_r[0] <= d_zero_r;
    v_nx_r[0]   <= d_nx_r;
    v_ny_r[0]   <= d_ny_r;
    // zero divisor only happens with the dead-zone flag set; keep it nonzero
    v_m_r[0]    <= d_zero_r ? W'(1) : d_m_r;
    v_px_r[0]   <= d_zero_r ? '0 : e_px_nxt;
    v_py_r[0]   <= d_zero_r ? '0 : e_py_nxt;
    v_rx_r[0]   <= '0;
    v_ry_r[0]   <= '0;
    v_qx_r[0]   <= '0;
    v_qy_r[0]   <= '0;
  end

  // ---------------- restoring divide: one quotient bit per stage ----------
  // |c|*d < m * 2^W, so the quotient fits W bits; the upper dividend half is
  // seeded into the remainder at the first step, and the low half is shifted in
  // one bit per step. To keep one shift per step there are W steps, each a
  // shift and a compare; the first step also loads the high half.
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W+1:0] shx_nxt, shy_nxt, mx_nxt;
    logic [W:0]   hix_nxt, hiy_nxt;
    logic         tx_nxt, ty_nxt;

    always_comb begin
      // at the first step the remainder is seeded with the high half
      hix_nxt = (k == 0) ? {1'b0, v_px_r[k][2*W-1:W]} : v_rx_r[k];
      hiy_nxt = (k == 0) ? {1'b0, v_py_r[k][2*W-1:W]} : v_ry_r[k];
      shx_nxt = {hix_nxt, v_px_r[k][W-1]};
      shy_nxt = {hiy_nxt, v_py_r[k][W-1]};
      mx_nxt  = {2'b00, v_m_r[k]};
      tx_nxt  = (shx_nxt >= mx_nxt);
      ty_nxt  = (shy_nxt >= mx_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_vld_r[k+1] <= 1'b0;
      end else begin
        v_vld_r[k+1] <= v_vld_r[k];
      end
      v_zero_r[k+1] <= v_zero_r[k];
      v_nx_r[k+1]   <= v_nx_r[k];
      v_ny_r[k+1]   <= v_ny_r[k];
      v_m_r[k+1]    <= v_m_r[k];
      v_px_r[k+1]   <= {v_px_r[k][2*W-1:W], v_px_r[k][W-2:0], 1'b0};
      v_py_r[k+1]   <= {v_py_r[k][2*W-1:W], v_py_r[k][W-2:0], 1'b0};
      // remainder stays below m < 2^W
      v_rx_r[k+1]   <= tx_nxt ? (W+1)'(shx_nxt - mx_nxt) : (W+1)'(shx_nxt);
      v_ry_r[k+1]   <= ty_nxt ? (W+1)'(shy_nxt - mx_nxt) : (W+1)'(shy_nxt);
      v_qx_r[k+1]   <= {v_qx_r[k][W-2:0], tx_nxt};
      v_qy_r[k+1]   <= {v_qy_r[k][W-2:0], ty_nxt};
    end
  end

  // ---------------- output stage: apply signs ----------------
  logic            o_vld_r;
  rdz_pkg::out_item_t o_data_r;
  logic [W-1:0]    o_x_nxt, o_y_nxt;

  always_comb begin
    o_x_nxt = v_nx_r[W] ? (~v_qx_r[W] + 1'b1) : v_qx_r[W];
    o_y_nxt = v_ny_r[W] ? (~v_qy_r[W] + 1'b1) : v_qy_r[W];
    if (v_zero_r[W]) begin
      o_x_nxt = '0;
      o_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= v_vld_r[W];
    end
    o_data_r.out_x <= o_x_nxt;
    o_data_r.out_y <= o_y_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule
